@@ design/krh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-gram rolling hash package
// Shared widths, codes, payload types and the control and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package krh_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int GRAM_W    = 7;
    localparam int HASH_W    = 64;
    localparam int IDX_W     = 32;
    localparam int LINE_W    = 24;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int MSEL_W    = 3;

    localparam logic [CMD_W-1:0] CMD_BYTE       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TOKEN_END  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEW_STREAM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAM_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_BASE = 1'd1;

    localparam logic [GRAM_W-1:0] GRAM_SIZE_RST = 7'd5;
    localparam logic [HASH_W-1:0] HASH_BASE_RST = 64'd257;

    localparam logic [MSEL_W-1:0] MSEL_ACC_BASE  = 3'd0;
    localparam logic [MSEL_W-1:0] MSEL_LP_BASE   = 3'd1;
    localparam logic [MSEL_W-1:0] MSEL_OLD_LP    = 3'd2;
    localparam logic [MSEL_W-1:0] MSEL_DIFF_BASE = 3'd3;
    localparam logic [MSEL_W-1:0] MSEL_ROLL_BASE = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] byte_value;
        logic [LINE_W-1:0] line;
    } item_t;

    typedef struct packed {
        logic [HASH_W-1:0] window_hash;
        logic [IDX_W-1:0]  start_index;
        logic [IDX_W-1:0]  end_index;
        logic [LINE_W-1:0] min_line;
        logic [LINE_W-1:0] max_line;
    } result_t;

    typedef struct packed {
        logic              latch_in;
        logic              new_stream;
        logic              mul_start;
        logic [MSEL_W-1:0] mul_sel;
        logic              acc_byte;
        logic              tok_value;
        logic              pwr_step;
        logic              roll_load;
        logic              commit;
        logic              scan_step;
        logic              out_load;
    } krh_ctl_t;

    typedef struct packed {
        logic mul_done;
        logic pwr_done;
        logic k_zero;
        logic k_one;
        logic full_before;
        logic emit;
        logic scan_last;
    } krh_sts_t;

endpackage

@@ design/krh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krh_ram
    import krh_pkg::*;
#(
    parameter int WIDTH = HASH_W,
    parameter int DEPTH = WINDOW_MAX_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/krh_mul64.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative 64-bit modular multiplier
// Forms the low 64 bits of a 64 by 64 product with one shared 32 by 32
// multiplier. A new start restarts the sequence.
// ----------------------------------------------------------------------------
module krh_mul64
    import krh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] a,
    input  logic [HASH_W-1:0] b,
    output logic              done,
    output logic [HASH_W-1:0] product
);

    localparam int HALF_W = HASH_W / 2;

    localparam logic [1:0] STEP_LL  = 2'd0;
    localparam logic [1:0] STEP_LH  = 2'd1;
    localparam logic [1:0] STEP_HL  = 2'd2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [1:0]        step_reg, step_next;
    logic [HASH_W-1:0] a_reg, a_next;
    logic [HASH_W-1:0] b_reg, b_next;
    logic [HASH_W-1:0] ll_reg, ll_next;
    logic [HALF_W-1:0] cross_reg, cross_next;
    logic [HASH_W-1:0] prod_reg, prod_next;

    logic [HALF_W-1:0] op_x;
    logic [HALF_W-1:0] op_y;
    logic [HASH_W-1:0] pp;

    assign op_x = (step_reg == STEP_HL) ? a_reg[HASH_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign op_y = (step_reg == STEP_LH) ? b_reg[HASH_W-1:HALF_W] : b_reg[HALF_W-1:0];
    assign pp   = op_x * op_y;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ll_next    = ll_reg;
        cross_next = cross_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            busy_next = 1'b1;
            step_next = STEP_LL;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                STEP_LL:
                begin
                    ll_next   = pp;
                    step_next = STEP_LH;
                end
                STEP_LH:
                begin
                    cross_next = pp[HALF_W-1:0];
                    step_next  = STEP_HL;
                end
                STEP_HL:
                begin
                    prod_next = {ll_reg[HASH_W-1:HALF_W] + cross_reg + pp[HALF_W-1:0],
                                 ll_reg[HALF_W-1:0]};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        ll_reg    <= ll_next;
        cross_reg <= cross_next;
        prod_reg  <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

@@ design/krh_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-gram rolling hash datapath
// Holds the hash state, the token and line windows, the shared multiplier
// and the result register, and carries out the controller's commands.
// ----------------------------------------------------------------------------
module krh_datapath
    import krh_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  item_t                item,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]    cfg_wdata,
    input  krh_ctl_t             ctl,
    output krh_sts_t             sts,
    output result_t              result
);

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int AW     = SLOT_W + 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);
    localparam logic [AW-1:0]     WMAX_AW   = AW'(WINDOW_MAX);

    logic [GRAM_W-1:0] gram_reg, gram_next;
    logic [HASH_W-1:0] base_reg, base_next;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [HASH_W-1:0] lp_reg, lp_next;
    logic [HASH_W-1:0] roll_reg, roll_next;
    logic [IDX_W-1:0]  tokens_reg, tokens_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [GRAM_W-1:0] cnt_reg, cnt_next;

    item_t             item_reg, item_next;
    logic [HASH_W-1:0] v_reg, v_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [LINE_W-1:0] lo_reg, lo_next;
    logic [LINE_W-1:0] hi_reg, hi_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    result_t           result_reg, result_next;

    logic [GRAM_W-1:0] k;
    logic [AW-1:0]     slot_ext;
    logic [AW-1:0]     k_ext;
    logic [AW-1:0]     old_ext;
    logic [SLOT_W-1:0] old_slot;
    logic [IDX_W-1:0]  tokens_inc;
    logic [HASH_W-1:0] old_value;
    logic [LINE_W-1:0] line_rdata;

    logic              mul_done;
    logic [HASH_W-1:0] mul_prod;
    logic [HASH_W-1:0] mul_a;
    logic [HASH_W-1:0] mul_b;

    assign k        = (int'(gram_reg) > WINDOW_MAX) ? GRAM_W'(WINDOW_MAX) : gram_reg;
    assign slot_ext = {1'b0, slot_reg};
    assign k_ext    = AW'(k);
    assign old_ext  = (slot_ext >= k_ext) ? (slot_ext - k_ext) : (slot_ext + WMAX_AW - k_ext);
    assign old_slot = old_ext[SLOT_W-1:0];
    assign tokens_inc = (tokens_reg == {IDX_W{1'b1}}) ? tokens_reg : (tokens_reg + 32'd1);

    always_comb
    begin
        mul_b = base_reg;
        case (ctl.mul_sel)
            MSEL_ACC_BASE:  mul_a = acc_reg;
            MSEL_LP_BASE:   mul_a = lp_reg;
            MSEL_OLD_LP:
            begin
                mul_a = old_value;
                mul_b = lp_reg;
            end
            MSEL_DIFF_BASE: mul_a = roll_reg - mul_prod;
            MSEL_ROLL_BASE: mul_a = roll_reg;
            default:        mul_a = acc_reg;
        endcase
    end

    krh_mul64 u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctl.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    krh_ram
    #(
        .WIDTH (HASH_W),
        .DEPTH (WINDOW_MAX)
    )
    u_value_ram
    (
        .clk   (clk),
        .we    (ctl.commit),
        .waddr (slot_reg),
        .wdata (v_reg),
        .raddr (old_slot),
        .rdata (old_value)
    );

    krh_ram
    #(
        .WIDTH (LINE_W),
        .DEPTH (WINDOW_MAX)
    )
    u_line_ram
    (
        .clk   (clk),
        .we    (ctl.commit),
        .waddr (slot_reg),
        .wdata (item_reg.line),
        .raddr (ptr_reg),
        .rdata (line_rdata)
    );

    always_comb
    begin
        gram_next   = gram_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        lp_next     = lp_reg;
        roll_next   = roll_reg;
        tokens_next = tokens_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        item_next   = item_reg;
        v_next      = v_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ptr_next    = ptr_reg;
        result_next = result_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_GRAM_SIZE: gram_next = cfg_wdata[GRAM_W-1:0];
                CFG_HASH_BASE: base_next = cfg_wdata;
                default:       ;
            endcase
            acc_next    = '0;
            roll_next   = '0;
            tokens_next = '0;
            slot_next   = '0;
            lp_next     = 64'd1;
            cnt_next    = '0;
        end
        else
        begin
            if (ctl.latch_in)
            begin
                item_next = item;
            end
            if (ctl.new_stream)
            begin
                acc_next    = '0;
                roll_next   = '0;
                tokens_next = '0;
                slot_next   = '0;
            end
            if (ctl.acc_byte)
            begin
                acc_next = mul_prod + 64'(item_reg.byte_value) + 64'd1;
            end
            if (ctl.tok_value)
            begin
                v_next   = mul_prod + 64'd1;
                acc_next = '0;
            end
            if (ctl.pwr_step)
            begin
                lp_next  = mul_prod;
                cnt_next = cnt_reg + 7'd1;
            end
            if (ctl.roll_load)
            begin
                roll_next = mul_prod + v_reg;
            end
            if (ctl.commit)
            begin
                slot_next   = (slot_reg == SLOT_LAST) ? '0 : (slot_reg + 1'b1);
                tokens_next = tokens_inc;
                idx_next    = tokens_reg;
                lo_next     = item_reg.line;
                hi_next     = item_reg.line;
                cnt_next    = 7'd1;
                ptr_next    = (slot_reg == '0) ? SLOT_LAST : (slot_reg - 1'b1);
            end
            if (ctl.scan_step)
            begin
                lo_next = (line_rdata < lo_reg) ? line_rdata : lo_reg;
                hi_next = (line_rdata > hi_reg) ? line_rdata : hi_reg;
                cnt_next = cnt_reg + 7'd1;
                ptr_next = (ptr_reg == '0) ? SLOT_LAST : (ptr_reg - 1'b1);
            end
            if (ctl.out_load)
            begin
                result_next.window_hash = roll_reg;
                result_next.start_index = idx_reg - (32'(k) - 32'd1);
                result_next.end_index   = idx_reg;
                result_next.min_line    = lo_reg;
                result_next.max_line    = hi_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gram_reg   <= GRAM_SIZE_RST;
            base_reg   <= HASH_BASE_RST;
            acc_reg    <= '0;
            lp_reg     <= 64'd1;
            roll_reg   <= '0;
            tokens_reg <= '0;
            slot_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            gram_reg   <= gram_next;
            base_reg   <= base_next;
            acc_reg    <= acc_next;
            lp_reg     <= lp_next;
            roll_reg   <= roll_next;
            tokens_reg <= tokens_next;
            slot_reg   <= slot_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        v_reg      <= v_next;
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        ptr_reg    <= ptr_next;
        result_reg <= result_next;
    end

    assign sts.mul_done    = mul_done;
    assign sts.pwr_done    = ({1'b0, cnt_reg} + 8'd1) >= {1'b0, k};
    assign sts.k_zero      = (k == '0);
    assign sts.k_one       = (k == 7'd1);
    assign sts.full_before = (tokens_reg >= 32'(k));
    assign sts.emit        = (k != '0) && (tokens_inc >= 32'(k));
    assign sts.scan_last   = (cnt_reg == (k - 7'd1));

    assign result = result_reg;

endmodule

@@ design/krh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-gram rolling hash controller
// Sequences each accepted item through the datapath and owns both
// handshakes, including the result register's valid flag.
// ----------------------------------------------------------------------------
module krh_ctrl
    import krh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [CMD_W-1:0] item_cmd,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  logic             cfg_wr_en,
    input  krh_sts_t         sts,
    output krh_ctl_t         ctl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BYTE_W = 4'd1;
    localparam logic [3:0] S_TOKV_W = 4'd2;
    localparam logic [3:0] S_SUB_W  = 4'd3;
    localparam logic [3:0] S_ROLL_W = 4'd4;
    localparam logic [3:0] S_COMMIT = 4'd5;
    localparam logic [3:0] S_SCAN_A = 4'd6;
    localparam logic [3:0] S_SCAN_B = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;
    localparam logic [3:0] S_PWR    = 4'd9;
    localparam logic [3:0] S_PWR_W  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.mul_sel = MSEL_ACC_BASE;

        if (cfg_wr_en)
        begin
            state_next = S_PWR;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ctl.latch_in = 1'b1;
                        unique case (item_cmd)
                            CMD_BYTE:
                            begin
                                ctl.mul_start = 1'b1;
                                state_next    = S_BYTE_W;
                            end
                            CMD_TOKEN_END:
                            begin
                                ctl.mul_start = 1'b1;
                                state_next    = S_TOKV_W;
                            end
                            CMD_NEW_STREAM:
                            begin
                                ctl.new_stream = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_BYTE_W:
                begin
                    if (sts.mul_done)
                    begin
                        ctl.acc_byte = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                S_TOKV_W:
                begin
                    if (sts.mul_done)
                    begin
                        ctl.tok_value = 1'b1;
                        if (sts.k_zero)
                        begin
                            state_next = S_COMMIT;
                        end
                        else if (sts.full_before)
                        begin
                            ctl.mul_start = 1'b1;
                            ctl.mul_sel   = MSEL_OLD_LP;
                            state_next    = S_SUB_W;
                        end
                        else
                        begin
                            ctl.mul_start = 1'b1;
                            ctl.mul_sel   = MSEL_ROLL_BASE;
                            state_next    = S_ROLL_W;
                        end
                    end
                end
                S_SUB_W:
                begin
                    if (sts.mul_done)
                    begin
                        ctl.mul_start = 1'b1;
                        ctl.mul_sel   = MSEL_DIFF_BASE;
                        state_next    = S_ROLL_W;
                    end
                end
                S_ROLL_W:
                begin
                    if (sts.mul_done)
                    begin
                        ctl.roll_load = 1'b1;
                        state_next    = S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    ctl.commit = 1'b1;
                    if (!sts.emit)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.k_one)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCAN_A;
                    end
                end
                S_SCAN_A:
                begin
                    state_next = S_SCAN_B;
                end
                S_SCAN_B:
                begin
                    ctl.scan_step = 1'b1;
                    state_next    = sts.scan_last ? S_OUT : S_SCAN_A;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || result_ready)
                    begin
                        ctl.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                S_PWR:
                begin
                    if (sts.pwr_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.mul_start = 1'b1;
                        ctl.mul_sel   = MSEL_LP_BASE;
                        state_next    = S_PWR_W;
                    end
                end
                S_PWR_W:
                begin
                    if (sts.mul_done)
                    begin
                        ctl.pwr_step = 1'b1;
                        state_next   = S_PWR;
                    end
                end
                default:
                begin
                    state_next = S_PWR;
                end
            endcase
        end
    end

    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_PWR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

@@ design/kgram_rolling_hash_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-gram rolling hash unit
// Folds a token stream into token values and emits a polynomial rolling
// hash, token index range and line range for every full window of tokens.
//
// Items arrive on a valid/ready channel: a text byte, an end-of-token mark
// with its source line, or a start-of-stream mark. Results leave on a second
// valid/ready channel; one transfer follows each end-of-token mark that
// completes a window of gram_size tokens. The user must write registers
// through the plain write port only while the unit is idle; the block itself
// does not enforce this. Every 64-bit product is formed on one shared
// 32 by 32 multiplier from three partial products. An end-of-token mark
// forms its token value and rolls it into the hash, first taking out the
// oldest token's term once the window is full; a mark that completes a
// window then scans k - 1 lines from the line memory and loads the result
// register, where k is gram_size capped at WINDOW_MAX. After reset and
// after every register write the unit forms base^(k-1) before it takes
// an item. A result waits in the output register while the receiver stalls;
// the next item is still taken, and only a second result waits for the
// register to empty.
// ----------------------------------------------------------------------------
module kgram_rolling_hash_unit
    import krh_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]    cfg_wdata
);

    krh_ctl_t ctl;
    krh_sts_t sts;

    krh_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_cmd     (item.cmd),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cfg_wr_en    (cfg_wr_en),
        .sts          (sts),
        .ctl          (ctl)
    );

    krh_datapath
    #(
        .WINDOW_MAX (WINDOW_MAX)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts),
        .result    (result)
    );

endmodule
